### hw/rtl/can_tx_dual_priority_queue_macros.svh
// Assertion macros used by the transmit queue control module.
`ifndef CAN_TX_DUAL_PRIORITY_QUEUE_MACROS_SVH
`define CAN_TX_DUAL_PRIORITY_QUEUE_MACROS_SVH

// Checked on every clock edge outside reset.
`define CTDPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ctdpq assertion failed");

// Checked on every clock edge, reset included.
`define CTDPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ctdpq assertion failed");

`endif

### hw/rtl/ctdpq_pkg.sv
// Package: types, sizes and codes of the CAN transmit dual priority queue.
package ctdpq_pkg;

  localparam int DEPTH     = 16;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int LIMIT_W   = 5;
  localparam int PEND_W    = 6;
  localparam int CLS_W     = 3;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] FUNC_ENQ     = 2'd0;
  localparam logic [1:0] FUNC_DEQ     = 2'd1;
  localparam logic [1:0] FUNC_CLR     = 2'd2;
  localparam logic [1:0] FUNC_RESTORE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PAUSED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef struct packed {
    logic [1:0]  func;
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic        urgent;
  } req_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_valid;
    logic [10:0]       out_can_id;
    logic [3:0]        out_dlc;
    logic [63:0]       out_payload;
    logic [PEND_W-1:0] pending_count;
    logic [CLS_W-1:0]  service_class;
  } rsp_t;

  typedef struct packed {
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    logic              paused;
    logic [LIMIT_W-1:0] queue_limit;
  } cfg_t;

  typedef struct packed {
    logic             we_urgent;
    logic             we_normal;
    logic [PTR_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic             rd_urgent;
    logic [PTR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              accepted;
    logic [PEND_W-1:0] pending_count;
    logic [CLS_W-1:0]  service_class;
  } stat_t;

endpackage

### hw/rtl/ctdpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ctdpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ctdpq_ctrl.sv
// Queue control: read pointers, fill counts, classification and memory requests.
`include "can_tx_dual_priority_queue_macros.svh"

module ctdpq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                acc,
  input  ctdpq_pkg::req_t     req,
  input  ctdpq_pkg::cfg_t     cfg,
  output ctdpq_pkg::mem_req_t mem,
  output ctdpq_pkg::stat_t    stat
);
  import ctdpq_pkg::*;

  localparam logic [CLS_W-1:0] CLS_NMT   = 3'd0;
  localparam logic [CLS_W-1:0] CLS_SYNC  = 3'd1;
  localparam logic [CLS_W-1:0] CLS_EMCY  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_SDO   = 3'd3;
  localparam logic [CLS_W-1:0] CLS_PDO   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_HBEAT = 3'd5;
  localparam logic [CLS_W-1:0] CLS_OTHER = 3'd6;

  localparam logic [10:0] ID_NMT     = 11'h000;
  localparam logic [10:0] ID_SYNC    = 11'h080;
  localparam logic [10:0] FC_MASK    = 11'h780;
  localparam logic [10:0] FC_EMCY    = 11'h100;
  localparam logic [10:0] FC_SDO_TX  = 11'h580;
  localparam logic [10:0] FC_SDO_RX  = 11'h600;
  localparam logic [10:0] FC_PDO1_TX = 11'h180;
  localparam logic [10:0] FC_PDO1_RX = 11'h200;
  localparam logic [10:0] FC_HBEAT   = 11'h700;
  localparam logic [3:0]  DLC_MAX    = 4'd8;

  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int SUM_W = (CNT_W + 1 > PEND_W) ? CNT_W + 1 : PEND_W;
  localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  function automatic logic [CLS_W-1:0] classify(input logic [10:0] id);
    logic [10:0] fc;
    fc = id & FC_MASK;
    priority if (id == ID_NMT) return CLS_NMT;
    else if (id == ID_SYNC) return CLS_SYNC;
    else if (fc == FC_EMCY) return CLS_EMCY;
    else if (fc == FC_SDO_TX || fc == FC_SDO_RX) return CLS_SDO;
    else if (fc == FC_PDO1_TX || fc == FC_PDO1_RX) return CLS_PDO;
    else if (fc == FC_HBEAT) return CLS_HBEAT;
    else return CLS_OTHER;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic [PTR_W-1:0] u_rd, u_rd_next, n_rd, n_rd_next;
  logic [CNT_W-1:0] u_fill, u_fill_next, n_fill, n_fill_next;

  logic [CLS_W-1:0] cls;
  logic             sel_urgent;
  logic             do_push;
  logic             push_ok;
  logic [CNT_W-1:0] fill_sel;
  logic [PTR_W-1:0] rd_sel;
  logic [CMP_W-1:0] eff_limit;
  logic [PTR_W:0]   wsum;
  logic             deq_u, deq_n;
  logic [3:0]       dlc_sat;
  logic [SUM_W-1:0] pend_sum;

  always_comb begin
    cls        = classify(req.can_id);
    sel_urgent = (req.func == FUNC_ENQ) ? req.urgent : (cls != CLS_OTHER);
    do_push    = ((req.func == FUNC_ENQ) && !cfg.paused) || (req.func == FUNC_RESTORE);
    fill_sel   = sel_urgent ? u_fill : n_fill;
    rd_sel     = sel_urgent ? u_rd : n_rd;
    eff_limit  = (CMP_W'(cfg.queue_limit) > DEPTH_C) ? DEPTH_C : CMP_W'(cfg.queue_limit);
    push_ok    = do_push && (CMP_W'(fill_sel) < eff_limit);
    wsum       = (PTR_W + 1)'(rd_sel) + (PTR_W + 1)'(fill_sel);
    if (wsum >= DEPTH_P) begin
      wsum = wsum - DEPTH_P;
    end
    deq_u   = (req.func == FUNC_DEQ) && (u_fill != '0);
    deq_n   = (req.func == FUNC_DEQ) && (u_fill == '0) && (n_fill != '0);
    dlc_sat = (req.dlc > DLC_MAX) ? DLC_MAX : req.dlc;

    u_rd_next   = u_rd;
    n_rd_next   = n_rd;
    u_fill_next = u_fill;
    n_fill_next = n_fill;
    if (req.func == FUNC_CLR) begin
      u_rd_next   = '0;
      n_rd_next   = '0;
      u_fill_next = '0;
      n_fill_next = '0;
    end else if (deq_u) begin
      u_rd_next   = ptr_inc(u_rd);
      u_fill_next = u_fill - 1'b1;
    end else if (deq_n) begin
      n_rd_next   = ptr_inc(n_rd);
      n_fill_next = n_fill - 1'b1;
    end else if (push_ok && sel_urgent) begin
      u_fill_next = u_fill + 1'b1;
    end else if (push_ok) begin
      n_fill_next = n_fill + 1'b1;
    end

    pend_sum = SUM_W'(u_fill_next) + SUM_W'(n_fill_next);

    mem.we_urgent    = acc && push_ok && sel_urgent;
    mem.we_normal    = acc && push_ok && !sel_urgent;
    mem.waddr        = wsum[PTR_W-1:0];
    mem.wdata        = '{can_id: req.can_id, dlc: dlc_sat, payload: req.payload};
    mem.re           = acc && (deq_u || deq_n);
    mem.rd_urgent    = deq_u;
    mem.raddr        = deq_u ? u_rd : n_rd;

    stat.accepted      = push_ok;
    stat.pending_count = pend_sum[PEND_W-1:0];
    stat.service_class = (req.func == FUNC_RESTORE) ? cls : CLS_NMT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_rd   <= '0;
      n_rd   <= '0;
      u_fill <= '0;
      n_fill <= '0;
    end else if (acc) begin
      u_rd   <= u_rd_next;
      n_rd   <= n_rd_next;
      u_fill <= u_fill_next;
      n_fill <= n_fill_next;
    end
  end

  `CTDPQ_ASSERT(a_fill_bound, (CMP_W'(u_fill) <= DEPTH_C) && (CMP_W'(n_fill) <= DEPTH_C))
  `CTDPQ_ASSERT(a_push_urgent, acc && push_ok && sel_urgent && (req.func != FUNC_DEQ) |=> u_fill == $past(u_fill) + 1'b1)
  `CTDPQ_ASSERT(a_deq_urgent_first, acc && deq_u |=> (u_fill == $past(u_fill) - 1'b1) && $stable(n_fill))
  `CTDPQ_ASSERT(a_clear, acc && (req.func == FUNC_CLR) |=> (u_fill == '0) && (n_fill == '0))
  `CTDPQ_ASSERT(a_single_write, !(mem.we_urgent && mem.we_normal) && !(mem.re && (mem.we_urgent || mem.we_normal)))

endmodule

### hw/rtl/can_tx_dual_priority_queue.sv
// Top level of the CAN transmit dual priority queue.
// Two FIFOs of DEPTH frames (urgent and normal) kept in two entry memories with
// registered read data. An enqueue, restore, clear or dequeue finding no frame
// is registered into the output register when accepted; a dequeue that finds a
// frame reads its entry memory, enters ST_READ, then registers that data. A new
// item is taken once the previous one has finished and the output register is
// empty or being drained in the same cycle. Dequeue serves the urgent FIFO first;
// restore routes by the CANopen function code of the identifier and ignores pause.
// No clearing pass is needed after reset: fill counts track occupancy.
module can_tx_dual_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  ctdpq_pkg::req_t                   req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output ctdpq_pkg::rsp_t                   rsp,
  input  logic                              cfg_we,
  input  logic [ctdpq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ctdpq_pkg::CFG_W-1:0]       cfg_data
);
  import ctdpq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic     state;
  logic     acc;
  cfg_t     cfg;
  mem_req_t mem;
  stat_t    stat;
  logic     rd_urgent;
  logic [PEND_W-1:0] hold_count;
  entry_t   u_rdata, n_rdata, rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.paused      <= 1'b0;
      cfg.queue_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAUSED: cfg.paused      <= cfg_data[0];
        CFG_LIMIT:  cfg.queue_limit <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  assign req_ready = (state == ST_IDLE) && (!rsp_valid || rsp_ready);
  assign acc       = req_valid && req_ready;

  ctdpq_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .req  (req),
    .cfg  (cfg),
    .mem  (mem),
    .stat (stat)
  );

  ctdpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram_urgent (
    .clk   (clk),
    .we    (mem.we_urgent),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re && mem.rd_urgent),
    .raddr (mem.raddr),
    .rdata (u_rdata)
  );

  ctdpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_ram_normal (
    .clk   (clk),
    .we    (mem.we_normal),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re && !mem.rd_urgent),
    .raddr (mem.raddr),
    .rdata (n_rdata)
  );

  assign rd_entry = rd_urgent ? u_rdata : n_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (acc && mem.re) begin
            state     <= ST_READ;
            rsp_valid <= 1'b0;
          end else if (acc) begin
            rsp_valid <= 1'b1;
          end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
        end
        ST_READ: begin
          state     <= ST_IDLE;
          rsp_valid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_urgent  <= mem.rd_urgent;
      hold_count <= stat.pending_count;
      rsp <= '{accepted: stat.accepted, frame_valid: 1'b0, out_can_id: '0, out_dlc: '0,
               out_payload: '0, pending_count: stat.pending_count,
               service_class: stat.service_class};
    end else if (state == ST_READ) begin
      rsp <= '{accepted: 1'b0, frame_valid: 1'b1, out_can_id: rd_entry.can_id,
               out_dlc: rd_entry.dlc, out_payload: rd_entry.payload,
               pending_count: hold_count, service_class: '0};
    end
  end

endmodule

### dv/ctdpq_txq_checker.sv
// Checker for the CAN transmit queue: predicts each item's result and compares it.
`timescale 1ns / 100ps
module ctdpq_txq_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  ctdpq_pkg::req_t                 req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  ctdpq_pkg::rsp_t                 rsp,
  input  logic                            cfg_we,
  input  logic [ctdpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctdpq_pkg::CFG_W-1:0]     cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import ctdpq_pkg::*;

  localparam logic [CLS_W-1:0] SVC_NMT       = 3'd0;
  localparam logic [CLS_W-1:0] SVC_SYNC      = 3'd1;
  localparam logic [CLS_W-1:0] SVC_EMCY      = 3'd2;
  localparam logic [CLS_W-1:0] SVC_SDO       = 3'd3;
  localparam logic [CLS_W-1:0] SVC_PDO       = 3'd4;
  localparam logic [CLS_W-1:0] SVC_HEARTBEAT = 3'd5;
  localparam logic [CLS_W-1:0] SVC_OTHER     = 3'd6;

  localparam logic [10:0] ID_NMT       = 11'h000;
  localparam logic [10:0] ID_SYNC      = 11'h080;
  localparam logic [10:0] FC_MASK      = 11'h780;
  localparam logic [10:0] FC_EMCY      = 11'h100;
  localparam logic [10:0] FC_SDO_TX    = 11'h580;
  localparam logic [10:0] FC_SDO_RX    = 11'h600;
  localparam logic [10:0] FC_PDO_A     = 11'h180;
  localparam logic [10:0] FC_PDO_B     = 11'h200;
  localparam logic [10:0] FC_HEARTBEAT = 11'h700;

  entry_t             urg_mem [DEPTH];
  entry_t             nrm_mem [DEPTH];
  int                 urg_head, urg_fill, nrm_head, nrm_fill;
  logic               paused_r;
  logic [LIMIT_W-1:0] limit_r;
  rsp_t               outcome_q [$];
  rsp_t               want;

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic report(input string msg);
    // quiet after the first hundred so a broken build stays readable
    if (mismatches < 100) $display("[%0t] ERROR %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val)
      report($sformatf("%s: got %0h, predicted %0h", field, got, exp_val));
  endtask

  function automatic logic store_frame(input logic to_urgent, input entry_t e);
    int cap;
    cap = (limit_r > DEPTH) ? DEPTH : int'(limit_r);
    if (to_urgent) begin
      if (urg_fill >= cap) return 1'b0;
      urg_mem[(urg_head + urg_fill) % DEPTH] = e;
      urg_fill++;
    end else begin
      if (nrm_fill >= cap) return 1'b0;
      nrm_mem[(nrm_head + nrm_fill) % DEPTH] = e;
      nrm_fill++;
    end
    return 1'b1;
  endfunction

  function automatic rsp_t apply_queue_op(input req_t r);
    rsp_t             o;
    entry_t           e;
    entry_t           head;
    logic [10:0]      fc;
    logic [CLS_W-1:0] cls;
    o = '0;
    head = '0;
    e.can_id  = r.can_id;
    e.dlc     = (r.dlc > 4'd8) ? 4'd8 : r.dlc;
    e.payload = r.payload;
    case (r.func)
      FUNC_ENQ: begin
        if (!paused_r) o.accepted = store_frame(r.urgent, e);
      end
      FUNC_DEQ: begin
        if (urg_fill != 0) begin
          head = urg_mem[urg_head];
          urg_head = (urg_head + 1) % DEPTH;
          urg_fill--;
          o.frame_valid = 1'b1;
        end else if (nrm_fill != 0) begin
          head = nrm_mem[nrm_head];
          nrm_head = (nrm_head + 1) % DEPTH;
          nrm_fill--;
          o.frame_valid = 1'b1;
        end
        if (o.frame_valid) begin
          o.out_can_id  = head.can_id;
          o.out_dlc     = head.dlc;
          o.out_payload = head.payload;
        end
      end
      FUNC_CLR: begin
        urg_fill = 0;
        nrm_fill = 0;
        urg_head = 0;
        nrm_head = 0;
      end
      FUNC_RESTORE: begin
        fc = r.can_id & FC_MASK;
        if (r.can_id == ID_NMT) cls = SVC_NMT;
        else if (r.can_id == ID_SYNC) cls = SVC_SYNC;
        else if (fc == FC_EMCY) cls = SVC_EMCY;
        else if (fc == FC_SDO_TX || fc == FC_SDO_RX) cls = SVC_SDO;
        else if (fc == FC_PDO_A || fc == FC_PDO_B) cls = SVC_PDO;
        else if (fc == FC_HEARTBEAT) cls = SVC_HEARTBEAT;
        else cls = SVC_OTHER;
        o.service_class = cls;
        o.accepted = store_frame(cls != SVC_OTHER, e);
      end
    endcase
    o.pending_count = PEND_W'(urg_fill + nrm_fill);
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      urg_head = 0;
      urg_fill = 0;
      nrm_head = 0;
      nrm_fill = 0;
      paused_r = 1'b0;
      limit_r  = LIMIT_RESET;
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PAUSED: paused_r = cfg_data[0];
          CFG_LIMIT:  limit_r  = cfg_data[LIMIT_W-1:0];
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          report("result with no item waiting");
        end else begin
          want = outcome_q.pop_front();
          check_field("accepted", rsp.accepted, want.accepted);
          check_field("frame_valid", rsp.frame_valid, want.frame_valid);
          check_field("out_can_id", rsp.out_can_id, want.out_can_id);
          check_field("out_dlc", rsp.out_dlc, want.out_dlc);
          check_field("out_payload", rsp.out_payload, want.out_payload);
          check_field("pending_count", rsp.pending_count, want.pending_count);
          check_field("service_class", rsp.service_class, want.service_class);
        end
      end
      if (req_valid && req_ready) outcome_q = {outcome_q, apply_queue_op(req)};
    end
    outstanding = outcome_q.size();
  end

endmodule

### dv/tb_top.sv
// Testbench top for the CAN transmit queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
  import ctdpq_pkg::*;

  localparam int N_PH      = 9;
  localparam int PH_ITEMS  = 78;

  localparam logic [10:0] SVC_BASE [8] = '{11'h000, 11'h080, 11'h100, 11'h580,
                                           11'h600, 11'h180, 11'h200, 11'h700};
  localparam logic [10:0] RESTORE_IDS [10] = '{11'h000, 11'h080, 11'h17F, 11'h585,
                                               11'h67F, 11'h180, 11'h2FF, 11'h700,
                                               11'h7FF, 11'h001};
  localparam int FILL_BIAS [3] = '{75, 50, 25};

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_ready;
  req_t                 req;
  logic                 rsp_valid;
  logic                 rsp_ready;
  rsp_t                 rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   src_idle;
  int                   sink_idle;
  int                   n_items;

  can_tx_dual_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ctdpq_txq_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= sink_idle);
  end

  function automatic req_t mk(input logic [1:0] func, input logic [10:0] id,
                              input logic [3:0] dlc, input logic [63:0] data,
                              input logic urg);
    req_t r;
    r.func    = func;
    r.can_id  = id;
    r.dlc     = dlc;
    r.payload = data;
    r.urgent  = urg;
    return r;
  endfunction

  function automatic req_t rand_item(input int fill_bias);
    req_t r;
    int   pick;
    int   k;
    r.can_id  = 11'($urandom_range(2047));
    r.dlc     = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
    r.payload = {$urandom, $urandom};
    r.urgent  = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 3) r.func = FUNC_CLR;
    else if (pick < fill_bias) r.func = ($urandom_range(2) == 0) ? FUNC_RESTORE : FUNC_ENQ;
    else r.func = FUNC_DEQ;
    // steer most restores onto the service ranges
    if (r.func == FUNC_RESTORE && $urandom_range(3) != 0) begin
      k = $urandom_range(7);
      r.can_id = SVC_BASE[k] | ((k < 2) ? 11'h000 : 11'($urandom_range(127)));
    end
    return r;
  endfunction

  task automatic send(input req_t item);
    if ($urandom_range(99) < src_idle) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    n_items++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_regs(input logic pz, input logic [LIMIT_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PAUSED;
    cfg_data  <= CFG_W'(pz);
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= CFG_W'(lim);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic               pause_plan [N_PH];
    logic [LIMIT_W-1:0] limit_plan [N_PH];
    int                 ph;
    int                 i;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    src_idle  = 32;
    sink_idle = 80;
    n_items   = 0;
    pause_plan = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    limit_plan = '{5'd16, 5'd1, 5'd5, 5'd31, 5'd0, 5'd16, 5'd2, 5'd17, 5'd8};
    limit_plan[6] = 5'($urandom_range(15, 2));
    pause_plan[8] = 1'($urandom_range(1));
    limit_plan[8] = 5'($urandom_range(31));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    write_regs(1'b0, LIMIT_RESET);

    send(mk(FUNC_DEQ, 11'h000, 4'h0, 64'h0, 1'b0));
    send(mk(FUNC_ENQ, 11'h7FF, 4'hF, '1, 1'b0));
    send(mk(FUNC_ENQ, 11'h000, 4'h0, 64'h0, 1'b1));
    send(mk(FUNC_ENQ, 11'h123, 4'h8, 64'h0123_4567_89AB_CDEF, 1'b0));
    for (i = 0; i < 10; i++)
      send(mk(FUNC_RESTORE, RESTORE_IDS[i], 4'(i + 3), {$urandom, $urandom}, 1'b0));
    for (i = 0; i < 4; i++)
      send(mk(FUNC_DEQ, 11'h000, 4'h0, 64'h0, 1'b0));
    send(mk(FUNC_CLR, 11'h7FF, 4'hF, '1, 1'b1));
    send(mk(FUNC_DEQ, 11'h7FF, 4'hF, '1, 1'b1));
    send(mk(FUNC_ENQ, 11'h555, 4'h9, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
    send(mk(FUNC_DEQ, 11'h000, 4'h0, 64'h0, 1'b0));

    for (ph = 0; ph < N_PH; ph++) begin
      settle();
      write_regs(pause_plan[ph], limit_plan[ph]);
      case (ph * 3 / N_PH)
        0: begin src_idle = 32; sink_idle = 80; end
        1: begin src_idle = 80; sink_idle = 32; end
        default: begin src_idle = 0; sink_idle = 0; end
      endcase
      for (i = 0; i < PH_ITEMS; i++)
        send(rand_item(FILL_BIAS[(i / 12) % 3]));
    end

    settle();
    repeat (4) @(posedge clk);
    $display("Covered %0d items over %0d pause/limit settings and three idle profiles",
             n_items, N_PH + 1);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d items still waiting", outstanding);
    $display("Mismatches found");
    $finish;
  end

endmodule
